### hw/rtl/moravec_interest_macros.svh
// Assertion macros shared by the interest operator RTL.
`ifndef MORAVEC_INTEREST_MACROS_SVH
`define MORAVEC_INTEREST_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define MVI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define MVI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mvi_pkg.sv
// Types, constants and tables of the interest operator.
`timescale 1ns / 1ps
package mvi_pkg;

  // geometry
  localparam int MAX_SIDE = 64;
  localparam int SIDE_W   = 7;                  // config field width
  localparam int COL_W    = $clog2(MAX_SIDE);   // column index into line store
  localparam int ROW_W    = 7;
  localparam logic [ROW_W-1:0]  ROW_MAX  = {ROW_W{1'b1}};
  localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(3);
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'(16);

  // arithmetic
  localparam int PIX_W  = 16;
  localparam int DIFF_W = PIX_W + 1;
  localparam int MAG_W  = PIX_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 48;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHIP_HEIGHT = CFG_IDX_W'(1);

  // neighbor pairs formed per pixel: left, up-left, up, up-right
  localparam int NUM_PAIR = 4;
  localparam int NUM_DIR  = 8;
  localparam logic [1:0] PAIR_L  = 2'd0;
  localparam logic [1:0] PAIR_UL = 2'd1;
  localparam logic [1:0] PAIR_U  = 2'd2;
  localparam logic [1:0] PAIR_UR = 2'd3;

  // which pair feeds each direction sum
  localparam logic [1:0] DIR_SRC [NUM_DIR] = '{
    PAIR_UL, PAIR_L, PAIR_UR, PAIR_U, PAIR_U, PAIR_UR, PAIR_L, PAIR_UL
  };

  typedef struct packed {
    logic                    vld;
    logic signed [PIX_W-1:0] value;
  } pix_entry_t;

  typedef struct packed {
    pix_entry_t left;
    pix_entry_t up_left;
    pix_entry_t up;
    pix_entry_t up_right;
  } nbr_t;

  // control carried along the pipeline with each word
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [NUM_DIR-1:0] dir_en;
  } stage_ctl_t;

endpackage

### hw/rtl/mvi_line_buf.sv
// Line store memory with deferred write, read forwarding and neighbor window.
`timescale 1ns / 1ps
module mvi_line_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  mvi_pkg::pix_entry_t cur_i,
  input  logic [mvi_pkg::COL_W-1:0] col_i,
  input  logic                wrap_i,
  input  logic                last_i,
  output mvi_pkg::nbr_t       nbr_o
);
  import mvi_pkg::*;

  pix_entry_t mem [MAX_SIDE];
  pix_entry_t mem_rd_q;
  pix_entry_t fwd_data_q;
  logic       fwd_q;
  pix_entry_t prev_q;
  logic       pend_vld_q;
  logic [COL_W-1:0] pend_addr_q;
  pix_entry_t win0_q, win1_q, col0_q;
  pix_entry_t rd;
  logic [COL_W-1:0] rd_addr;
  logic       commit;

  // prefetch the entry right of the next pixel's up neighbor
  assign rd_addr = wrap_i ? COL_W'(1) : col_i + COL_W'(2);
  assign commit  = acc_i && pend_vld_q;
  assign rd      = fwd_q ? fwd_data_q : mem_rd_q;

  // memory: previous pixel lands one word late, read data registered
  always_ff @(posedge clk_i) begin
    if (commit) begin
      mem[pend_addr_q] <= prev_q;
    end
    if (acc_i) begin
      mem_rd_q   <= mem[rd_addr];
      fwd_q      <= pend_vld_q && (pend_addr_q == rd_addr);
      fwd_data_q <= prev_q;
    end
  end

  // pending write and previous pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      prev_q     <= '0;
    end else if (acc_i) begin
      pend_vld_q <= !(last_i && !wrap_i);
      prev_q     <= cur_i;
    end
  end

  // window of the previous line; entry 0 is mirrored for the line start
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      pend_addr_q <= col_i;
      if (commit && (pend_addr_q == '0)) begin
        col0_q <= prev_q;
      end
      win0_q <= win1_q;
      if (wrap_i) begin
        win1_q <= (commit && (pend_addr_q == '0)) ? prev_q : col0_q;
      end else begin
        win1_q <= rd;
      end
    end
  end

  assign nbr_o.left     = prev_q;
  assign nbr_o.up_left  = win0_q;
  assign nbr_o.up       = win1_q;
  assign nbr_o.up_right = rd;

endmodule

### hw/rtl/mvi_sqdiff.sv
// Two pipeline stages: capture of pixel pairs, then squared differences.
`timescale 1ns / 1ps
module mvi_sqdiff (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  mvi_pkg::stage_ctl_t         ctl_i,
  input  logic signed [mvi_pkg::PIX_W-1:0] cur_i,
  input  mvi_pkg::nbr_t               nbr_i,
  output mvi_pkg::stage_ctl_t         ctl_o,
  output logic [mvi_pkg::NUM_PAIR-1:0][mvi_pkg::SQ_W-1:0] sq_o
);
  import mvi_pkg::*;

  stage_ctl_t ctl1_q, ctl2_q;
  logic signed [PIX_W-1:0]  cur1_q;
  logic signed [PIX_W-1:0]  nb1_q [NUM_PAIR];
  logic signed [DIFF_W-1:0] diff [NUM_PAIR];
  logic [DIFF_W-1:0]        mag [NUM_PAIR];
  logic [NUM_PAIR-1:0][SQ_W-1:0] sq_d, sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (adv_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  // pair capture and square registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cur1_q         <= cur_i;
      nb1_q[PAIR_L]  <= nbr_i.left.value;
      nb1_q[PAIR_UL] <= nbr_i.up_left.value;
      nb1_q[PAIR_U]  <= nbr_i.up.value;
      nb1_q[PAIR_UR] <= nbr_i.up_right.value;
      sq_q           <= sq_d;
    end
  end

  // |c - n|^2, one squarer per pair
  always_comb begin
    for (int k = 0; k < NUM_PAIR; k++) begin
      diff[k] = {cur1_q[PIX_W-1], cur1_q} - {nb1_q[k][PIX_W-1], nb1_q[k]};
      mag[k]  = diff[k][DIFF_W-1] ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);
      sq_d[k] = mag[k][MAG_W-1:0] * mag[k][MAG_W-1:0];
    end
  end

  assign ctl_o = ctl2_q;
  assign sq_o  = sq_q;

endmodule

### hw/rtl/mvi_accum.sv
// Direction sums, registered minimum tree and output register.
`timescale 1ns / 1ps
module mvi_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvi_pkg::stage_ctl_t ctl_i,
  input  logic [mvi_pkg::NUM_PAIR-1:0][mvi_pkg::SQ_W-1:0] sq_i,
  output logic                adv_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [mvi_pkg::SUM_W-1:0] interest_value_o
);
  import mvi_pkg::*;

  function automatic logic [SUM_W-1:0] min2(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

  logic [NUM_DIR-1:0][SUM_W-1:0] sums_q, sum_new, snap_q;
  logic [3:0][SUM_W-1:0] ta_q;
  logic [1:0][SUM_W-1:0] tb_q;
  logic [SUM_W-1:0]      out_q;
  logic snap_vld_q, ta_vld_q, tb_vld_q, out_vld_q;
  logic adv;

  // pipeline holds only when a result meets a full output register
  assign adv   = !(tb_vld_q && out_vld_q && !out_ready_i);
  assign adv_o = adv;

  // saturating add of the selected square into each direction
  always_comb begin
    logic [SUM_W:0] ext;
    for (int d = 0; d < NUM_DIR; d++) begin
      ext = {1'b0, sums_q[d]}
          + ((ctl_i.dir_en[d]) ? (SUM_W+1)'(sq_i[DIR_SRC[d]]) : '0);
      sum_new[d] = ext[SUM_W] ? SUM_MAX : ext[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q     <= '0;
      snap_vld_q <= 1'b0;
      ta_vld_q   <= 1'b0;
      tb_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (adv) begin
        if (ctl_i.vld) begin
          sums_q <= ctl_i.last ? '0 : sum_new;
        end
        snap_vld_q <= ctl_i.vld && ctl_i.last;
        ta_vld_q   <= snap_vld_q;
        tb_vld_q   <= ta_vld_q;
      end
      if (adv && tb_vld_q) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // snapshot on the last pixel, then a three-level minimum
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ctl_i.vld && ctl_i.last) begin
        snap_q <= sum_new;
      end
      for (int i = 0; i < 4; i++) begin
        ta_q[i] <= min2(snap_q[2*i], snap_q[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
        tb_q[i] <= min2(ta_q[2*i], ta_q[2*i+1]);
      end
      if (tb_vld_q) begin
        out_q <= min2(tb_q[0], tb_q[1]);
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign interest_value_o = out_q;

endmodule

### hw/rtl/moravec_interest.sv
// Top level of the streaming interest operator over an image chip.
//
// channel  dir  handshake                  word
// in       in   in_valid_i / in_ready_o    pixel_i, pixel_valid_i, last_pixel_i
// out      out  out_valid_o / out_ready_i  interest_value_o
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pixel per cycle; the line store is read once and written at most once per pixel.
// A chip's result goes through the snapshot and minimum tree to the output register.
// Reset clears counters, sums and pipeline valids; the line store has no clearing pass.
// Input stalls only while a result reaches the end of the minimum tree and the
// output register still holds one that is not taken. Config is always ready.
`timescale 1ns / 1ps
`include "moravec_interest_macros.svh"
module moravec_interest (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [mvi_pkg::PIX_W-1:0]   pixel_i,
  input  logic                               pixel_valid_i,
  input  logic                               last_pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mvi_pkg::SUM_W-1:0]          interest_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mvi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mvi_pkg::SIDE_W-1:0]         cfg_data_i
);
  import mvi_pkg::*;

  function automatic logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] v);
    if (v < SIDE_MIN) return SIDE_MIN;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  // coordinate strictly inside the border of a side of length s
  function automatic logic inner(logic [7:0] c, logic [SIDE_W-1:0] s);
    return (c != 8'd0) && ((c + 8'd2) <= {1'b0, s});
  endfunction

  logic [SIDE_W-1:0] width_q, height_q, w, h;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [SIDE_W-1:0] col_ext;
  logic [7:0]        cx, cxm, cxp, ry, rym;
  logic acc, adv, wrap;
  logic pe_l, pe_ul, pe_u, pe_ur;
  logic v_l, v_ul, v_u, v_ur, cur_in;
  pix_entry_t cur;
  nbr_t       nbr;
  stage_ctl_t ctl0, ctl2;
  logic [NUM_PAIR-1:0][SQ_W-1:0] sq;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = adv;
  assign acc         = in_valid_i && adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIDE_RST;
      height_q <= SIDE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CHIP_WIDTH:  width_q  <= cfg_data_i;
        REG_CHIP_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w = clamp_side(width_q);
  assign h = clamp_side(height_q);

  // raster position
  assign col_ext = {1'b0, col_q};
  assign wrap    = (col_ext + SIDE_W'(1)) >= w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (last_pixel_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (wrap) begin
        col_q <= '0;
        if (row_q != ROW_MAX) begin
          row_q <= row_q + ROW_W'(1);
        end
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // pair existence and interior tests for the four neighbors
  assign cx  = {2'b00, col_q};
  assign cxm = cx - 8'd1;
  assign cxp = cx + 8'd1;
  assign ry  = {1'b0, row_q};
  assign rym = ry - 8'd1;

  assign pe_l  = (col_q != '0) && (col_ext <= w);
  assign pe_ul = (row_q != '0) && pe_l;
  assign pe_u  = (row_q != '0) && (col_ext < w);
  assign pe_ur = (row_q != '0) && ((col_ext + SIDE_W'(1)) < w);

  assign v_l  = pixel_valid_i && nbr.left.vld     && pe_l;
  assign v_ul = pixel_valid_i && nbr.up_left.vld  && pe_ul;
  assign v_u  = pixel_valid_i && nbr.up.vld       && pe_u;
  assign v_ur = pixel_valid_i && nbr.up_right.vld && pe_ur;

  assign cur_in = inner(cx, w) && inner(ry, h);

  always_comb begin
    ctl0.vld       = acc;
    ctl0.last      = last_pixel_i;
    ctl0.dir_en[0] = v_ul && cur_in;
    ctl0.dir_en[1] = v_l  && cur_in;
    ctl0.dir_en[2] = v_ur && inner(cxp, w) && inner(rym, h);
    ctl0.dir_en[3] = v_u  && cur_in;
    ctl0.dir_en[4] = v_u  && inner(cx, w)  && inner(rym, h);
    ctl0.dir_en[5] = v_ur && cur_in;
    ctl0.dir_en[6] = v_l  && inner(cxm, w) && inner(ry, h);
    ctl0.dir_en[7] = v_ul && inner(cxm, w) && inner(rym, h);
  end

  assign cur.vld   = pixel_valid_i;
  assign cur.value = pixel_i;

  mvi_line_buf u_line_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .cur_i  (cur),
    .col_i  (col_q),
    .wrap_i (wrap),
    .last_i (last_pixel_i),
    .nbr_o  (nbr)
  );

  mvi_sqdiff u_sqdiff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (ctl0),
    .cur_i  (pixel_i),
    .nbr_i  (nbr),
    .ctl_o  (ctl2),
    .sq_o   (sq)
  );

  mvi_accum u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl2),
    .sq_i             (sq),
    .adv_o            (adv),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .interest_value_o (interest_value_o)
  );

  // checks
  `MVI_ASSERT_IMP(a_stall_only_on_full_out, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without a held result")
  `MVI_ASSERT_NXT(a_restart_after_last, acc && last_pixel_i, (col_q == '0) && (row_q == '0), "chip did not restart after last pixel")
  `MVI_ASSERT_NXT(a_line_advance, acc && wrap && !last_pixel_i && (row_q != ROW_MAX), (col_q == '0) && (row_q == $past(row_q) + ROW_W'(1)), "line wrap did not advance the row")

endmodule
